@@ hdl/bfsp_pkg.sv @@
// Shared types and constants for the shortest-path block.
// Used by every module under hdl/; depends on nothing.
package bfsp_pkg;

  localparam int VTX_W        = 5;
  localparam int VCNT_W       = 6;
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_W       = 24;
  localparam int CFG_IDX_W    = 1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_EDGE,
    ST_DIST,
    ST_RELAX,
    ST_ORD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [VTX_W-1:0]         parent;
    logic signed [DIST_W-1:0] cost;
  } vtx_word_t;

  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] addr;
    vtx_word_t        data;
  } vtx_wr_t;

  typedef struct packed {
    logic                     update;
    logic signed [DIST_W-1:0] cost;
  } relax_res_t;

endpackage

@@ hdl/bellman_ford_shortest_path.sv @@
// Top level of the single-source shortest-path block: sequencer and ports.
// Depends on bfsp_pkg, bfsp_edge_mem, bfsp_vtx_mem and bfsp_relax.
//
// Edges are taken one per cycle while busy is low (a transfer is start high
// with busy low). The edge flagged last_edge starts the solve: busy rises and
// stays high until the last result. With n being num_vertices clamped to 2..32,
// the block first initialises the n vertex words, then relaxes each of the E
// stored edges (edge memory read, vertex memory read, one pass through the
// shared relax adder and compare with write-back) over n-1 passes, and then
// reads each of the n results out of the vertex memory. Each of the n results
// is presented for exactly one cycle under result_valid, ascending by vertex;
// the receiver cannot stall them. Edges beyond MAX_EDGES are dropped. Write
// configuration only while busy is low and no result is pending.
module bellman_ford_shortest_path #(
  parameter int MAX_EDGES   = bfsp_pkg::MAX_EDGES,
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bfsp_pkg::VTX_W-1:0]           edge_from,
  input  logic [bfsp_pkg::VTX_W-1:0]           edge_to,
  input  logic signed [WEIGHT_BITS-1:0]        edge_weight,
  input  logic                                 last_edge,
  input  logic                                 cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfsp_pkg::VCNT_W-1:0]          cfg_data,
  output logic                                 result_valid,
  output logic [bfsp_pkg::VTX_W-1:0]           vertex_index,
  output logic signed [bfsp_pkg::DIST_W-1:0]   distance,
  output logic                                 reachable,
  output logic [bfsp_pkg::VTX_W-1:0]           parent_vertex,
  output logic                                 last_result
);

  localparam int VW     = bfsp_pkg::VTX_W;
  localparam int NW     = bfsp_pkg::VCNT_W;
  localparam int EDGE_W = 2 * VW + WEIGHT_BITS;
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);

  bfsp_pkg::state_t state, state_next;

  logic [CNT_W-1:0] edge_count, edge_count_next;
  logic [EA_W-1:0]  e, e_next;
  logic [VW-1:0]    v, v_next;
  logic [VW-1:0]    pass, pass_next;
  logic [NW-1:0]    num_vertices, num_vertices_next;
  logic [VW-1:0]    source_vertex, source_vertex_next;

  logic                    result_valid_next;
  logic [VW-1:0]           vertex_index_next;
  logic signed [bfsp_pkg::DIST_W-1:0] distance_next;
  logic                    reachable_next;
  logic [VW-1:0]           parent_vertex_next;
  logic                    last_result_next;

  logic [NW-1:0]     n_eff;
  logic              accept;
  logic              room;
  logic              last_v;
  logic              last_e;
  logic              last_pass;
  logic [EDGE_W-1:0] edge_q;
  logic [VW-1:0]     ea;
  logic [VW-1:0]     eb;
  logic signed [WEIGHT_BITS-1:0] ew;
  logic              src_ok;

  bfsp_pkg::vtx_wr_t    vwr;
  logic [VW-1:0]        rd_a_addr;
  logic [VW-1:0]        rd_b_addr;
  bfsp_pkg::vtx_word_t  qa;
  bfsp_pkg::vtx_word_t  qb;
  bfsp_pkg::relax_res_t rres;

  assign busy   = (state != bfsp_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign room   = (edge_count < CNT_W'(MAX_EDGES));

  always_comb begin
    if (num_vertices < NW'(2)) begin
      n_eff = NW'(2);
    end else if (num_vertices > NW'(bfsp_pkg::MAX_VERTICES)) begin
      n_eff = NW'(bfsp_pkg::MAX_VERTICES);
    end else begin
      n_eff = num_vertices;
    end
  end

  assign last_v    = ({1'b0, v} + NW'(1)) == n_eff;
  assign last_pass = ({1'b0, pass} + NW'(2)) == n_eff;
  assign last_e    = (CNT_W'(e) + CNT_W'(1)) == edge_count;

  assign ea = edge_q[EDGE_W-1 -: VW];
  assign eb = edge_q[WEIGHT_BITS +: VW];
  assign ew = edge_q[WEIGHT_BITS-1:0];

  bfsp_edge_mem #(
    .DEPTH  (MAX_EDGES),
    .WIDTH  (EDGE_W),
    .ADDR_W (EA_W)
  ) u_edge_mem (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (edge_count[EA_W-1:0]),
    .wr_data ({edge_from, edge_to, edge_weight}),
    .rd_addr (e),
    .rd_data (edge_q)
  );

  assign rd_a_addr = (state == bfsp_pkg::ST_DIST) ? ea : v;
  assign rd_b_addr = eb;

  bfsp_vtx_mem u_vtx_mem (
    .clk       (clk),
    .wr        (vwr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (qa),
    .rd_b_data (qb)
  );

  // unreachable vertices sit at the maximum distance; only reached ones are lower
  assign src_ok = ({1'b0, ea} < n_eff) && ({1'b0, eb} < n_eff)
                  && (qa.cost != bfsp_pkg::DIST_MAX);

  bfsp_relax #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_relax (
    .src_ok (src_ok),
    .dist_a (qa.cost),
    .dist_b (qb.cost),
    .weight (ew),
    .res    (rres)
  );

  always_comb begin
    state_next         = state;
    edge_count_next    = edge_count;
    e_next             = e;
    v_next             = v;
    pass_next          = pass;
    num_vertices_next  = num_vertices;
    source_vertex_next = source_vertex;
    result_valid_next  = 1'b0;
    vertex_index_next  = vertex_index;
    distance_next      = distance;
    reachable_next     = reachable;
    parent_vertex_next = parent_vertex;
    last_result_next   = last_result;
    vwr                = '0;

    if (cfg_we) begin
      case (cfg_index)
        bfsp_pkg::REG_NUM_VERTICES:  num_vertices_next  = cfg_data;
        bfsp_pkg::REG_SOURCE_VERTEX: source_vertex_next = cfg_data[VW-1:0];
        default: ;
      endcase
    end

    case (state)
      bfsp_pkg::ST_IDLE: begin
        if (accept) begin
          if (room) begin
            edge_count_next = edge_count + CNT_W'(1);
          end
          if (last_edge) begin
            v_next     = '0;
            state_next = bfsp_pkg::ST_INIT;
          end
        end
      end
      bfsp_pkg::ST_INIT: begin
        vwr.en          = 1'b1;
        vwr.addr        = v;
        vwr.data.parent = v;
        vwr.data.cost   = (v == source_vertex) ? '0 : bfsp_pkg::DIST_MAX;
        if (last_v) begin
          pass_next  = '0;
          e_next     = '0;
          state_next = bfsp_pkg::ST_EDGE;
        end else begin
          v_next = v + VW'(1);
        end
      end
      bfsp_pkg::ST_EDGE: begin
        state_next = bfsp_pkg::ST_DIST;
      end
      bfsp_pkg::ST_DIST: begin
        state_next = bfsp_pkg::ST_RELAX;
      end
      bfsp_pkg::ST_RELAX: begin
        vwr.en          = rres.update;
        vwr.addr        = eb;
        vwr.data.parent = ea;
        vwr.data.cost   = rres.cost;
        state_next      = bfsp_pkg::ST_EDGE;
        if (last_e) begin
          e_next = '0;
          if (last_pass) begin
            v_next     = '0;
            state_next = bfsp_pkg::ST_ORD;
          end else begin
            pass_next = pass + VW'(1);
          end
        end else begin
          e_next = e + EA_W'(1);
        end
      end
      bfsp_pkg::ST_ORD: begin
        state_next = bfsp_pkg::ST_OUT;
      end
      bfsp_pkg::ST_OUT: begin
        result_valid_next  = 1'b1;
        vertex_index_next  = v;
        distance_next      = qa.cost;
        reachable_next     = (qa.cost != bfsp_pkg::DIST_MAX);
        parent_vertex_next = qa.parent;
        last_result_next   = last_v;
        if (last_v) begin
          edge_count_next = '0;
          state_next      = bfsp_pkg::ST_IDLE;
        end else begin
          v_next     = v + VW'(1);
          state_next = bfsp_pkg::ST_ORD;
        end
      end
      default: begin
        state_next = bfsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bfsp_pkg::ST_IDLE;
      edge_count    <= '0;
      e             <= '0;
      v             <= '0;
      pass          <= '0;
      num_vertices  <= NW'(bfsp_pkg::MAX_VERTICES);
      source_vertex <= '0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      edge_count    <= edge_count_next;
      e             <= e_next;
      v             <= v_next;
      pass          <= pass_next;
      num_vertices  <= num_vertices_next;
      source_vertex <= source_vertex_next;
      result_valid  <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    vertex_index  <= vertex_index_next;
    distance      <= distance_next;
    reachable     <= reachable_next;
    parent_vertex <= parent_vertex_next;
    last_result   <= last_result_next;
  end

`ifndef SYNTHESIS
  // a result strobe only follows a read-out cycle
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == bfsp_pkg::ST_OUT)
    else $error("result strobe outside read-out");

  a_trigger_starts_init: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_edge) |=> state == bfsp_pkg::ST_INIT)
    else $error("last edge did not start the solve");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CNT_W'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_vtx_write_phase: assert property (@(posedge clk) disable iff (rst)
    vwr.en |-> (state == bfsp_pkg::ST_INIT || state == bfsp_pkg::ST_RELAX))
    else $error("vertex memory written outside init or relax");

  a_done_clears_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> (edge_count == '0 && !busy))
    else $error("edge store not emptied after last result");
`endif

endmodule

@@ hdl/bfsp_edge_mem.sv @@
// Edge list memory: one write port, one registered read port.
// Depends on bfsp_pkg for default sizes.
module bfsp_edge_mem #(
  parameter int DEPTH  = bfsp_pkg::MAX_EDGES,
  parameter int WIDTH  = 2 * bfsp_pkg::VTX_W + bfsp_pkg::WEIGHT_BITS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/bfsp_vtx_mem.sv @@
// Per-vertex distance and parent memory: one write port, two registered reads.
// Depends on bfsp_pkg for the word and write types.
module bfsp_vtx_mem (
  input  logic                         clk,
  input  bfsp_pkg::vtx_wr_t            wr,
  input  logic [bfsp_pkg::VTX_W-1:0]   rd_a_addr,
  input  logic [bfsp_pkg::VTX_W-1:0]   rd_b_addr,
  output bfsp_pkg::vtx_word_t          rd_a_data,
  output bfsp_pkg::vtx_word_t          rd_b_data
);

  bfsp_pkg::vtx_word_t mem [bfsp_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

@@ hdl/bfsp_relax.sv @@
// Relaxation unit: saturating add of distance and weight, compare with target.
// Depends on bfsp_pkg for distance limits and the result struct.
module bfsp_relax #(
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS
) (
  input  logic                                 src_ok,
  input  logic signed [bfsp_pkg::DIST_W-1:0]   dist_a,
  input  logic signed [bfsp_pkg::DIST_W-1:0]   dist_b,
  input  logic signed [WEIGHT_BITS-1:0]        weight,
  output bfsp_pkg::relax_res_t                 res
);

  localparam int DW    = bfsp_pkg::DIST_W;
  localparam int SUM_W = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-DW){1'b0}}, bfsp_pkg::DIST_MAX};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-DW){1'b1}}, bfsp_pkg::DIST_MIN};

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] w_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [DW-1:0]    sat;

  assign a_ext = {{(SUM_W-DW){dist_a[DW-1]}}, dist_a};
  assign w_ext = {{(SUM_W-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};
  assign sum   = a_ext + w_ext;

  always_comb begin
    if (sum > SUM_MAX) begin
      sat = bfsp_pkg::DIST_MAX;
    end else if (sum < SUM_MIN) begin
      sat = bfsp_pkg::DIST_MIN;
    end else begin
      sat = sum[DW-1:0];
    end
    res.cost   = sat;
    res.update = src_ok && (sat < dist_b);
  end

endmodule
